// ----- rtl/adcc_pkg.sv -----
// ----------------------------------------------------------------------------
// adcc_pkg: shared types and constants of the ADC channel conditioner
// Field widths, calibration constants, register indexes and reset values, channel codes,
// fault bit positions and the control states.
package adcc_pkg;

  // fixed field widths
  localparam int CAL_BITS     = 12;
  localparam int ACC_BITS     = 24;
  localparam int LF_BITS      = 12;
  localparam int TEMP_BITS    = 20;
  localparam int VOLT_BITS    = 21;
  localparam int CHAN_BITS    = 2;
  localparam int FAULT_BITS   = 2;
  localparam int CFG_IDX_BITS = 2;

  // calibration constants
  localparam int TEMP_HOT     = 110;
  localparam int TEMP_COLD    = 30;
  localparam int TEMP_SPAN    = TEMP_HOT - TEMP_COLD;
  localparam int SUPPLY_SCALE = 330;
  localparam int SCALE_BITS   = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_TEMP_CAL_LOW  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TEMP_CAL_HIGH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_VREF_CAL      = 2'd2;

  // reset values of the calibration registers
  localparam logic [CAL_BITS-1:0] TEMP_CAL_LOW_RST  = 12'd1720;
  localparam logic [CAL_BITS-1:0] TEMP_CAL_HIGH_RST = 12'd1320;
  localparam logic [CAL_BITS-1:0] VREF_CAL_RST      = 12'd1500;

  // scan channel codes
  localparam logic [CHAN_BITS-1:0] CH_POT     = 2'd0;
  localparam logic [CHAN_BITS-1:0] CH_TEMP    = 2'd1;
  localparam logic [CHAN_BITS-1:0] CH_VREF    = 2'd2;
  localparam logic [CHAN_BITS-1:0] CH_IGNORED = 2'd3;

  // fault bit positions
  localparam int FAULT_TEMP = 0;
  localparam int FAULT_VREF = 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN
  } ctrl_state_t;

endpackage

// ----- rtl/adcc_in_if.sv -----
// ----------------------------------------------------------------------------
// adcc_in_if: sample stream
// valid/ready channel carrying one ADC sample and its end-of-scan flag.
// ----------------------------------------------------------------------------
interface adcc_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   end_of_sequence;

  modport source (output valid, output sample, output end_of_sequence, input ready);
  modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

// ----- rtl/adcc_out_if.sv -----
// ----------------------------------------------------------------------------
// adcc_out_if: result stream
// valid/ready channel carrying one conditioned result per sample.
// ----------------------------------------------------------------------------
interface adcc_out_if;
  logic                              valid;
  logic                              ready;
  logic [adcc_pkg::CHAN_BITS-1:0]    handled_channel;
  logic [adcc_pkg::LF_BITS-1:0]      filtered_pot;
  logic [adcc_pkg::TEMP_BITS-1:0]    temperature_c;
  logic [adcc_pkg::VOLT_BITS-1:0]    supply_centivolts;
  logic [adcc_pkg::FAULT_BITS-1:0]   divide_fault;

  modport source (output valid, output handled_channel, output filtered_pot,
                  output temperature_c, output supply_centivolts, output divide_fault,
                  input ready);
  modport sink   (input valid, input handled_channel, input filtered_pot,
                  input temperature_c, input supply_centivolts, input divide_fault,
                  output ready);
endinterface

// ----- rtl/adcc_ema_serial.sv -----
// ----------------------------------------------------------------------------
// adcc_ema_serial: bit-serial exponential average
// acc = acc - (acc >> FILTER_SHIFT) + sample, one accumulator bit per cycle.
// ----------------------------------------------------------------------------
module adcc_ema_serial #(
  parameter int FILTER_SHIFT = 12,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SAMPLE_BITS-1:0]       sample,
  output logic                         busy,
  output logic [adcc_pkg::LF_BITS-1:0] last_filtered
);
  localparam int ACC_W = adcc_pkg::ACC_BITS;
  localparam int LF_W  = adcc_pkg::LF_BITS;
  localparam int F_W   = ACC_W - FILTER_SHIFT;  // bits of acc >> FILTER_SHIFT
  localparam int CNT_W = $clog2(ACC_W);

  logic [ACC_W-1:0]       acc;
  logic [SAMPLE_BITS-1:0] smp;
  logic [CNT_W-1:0]       cnt;
  logic                   add_c;
  logic                   sub_b;

  logic a_bit, s_bit, f_bit, t_bit, r_bit, add_c_next, sub_b_next;

  always_comb begin
    a_bit = acc[0];
    s_bit = smp[0];
    // old bit (cnt + FILTER_SHIFT) still sits at position FILTER_SHIFT
    f_bit = (cnt < CNT_W'(F_W)) ? acc[FILTER_SHIFT] : 1'b0;
    t_bit      = a_bit ^ s_bit ^ add_c;
    add_c_next = (a_bit & s_bit) | (a_bit & add_c) | (s_bit & add_c);
    r_bit      = t_bit ^ f_bit ^ sub_b;
    sub_b_next = (~t_bit & f_bit) | (~t_bit & sub_b) | (f_bit & sub_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      acc           <= '0;
      last_filtered <= '0;
      cnt           <= '0;
      add_c         <= 1'b0;
      sub_b         <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      smp   <= sample;
      cnt   <= '0;
      add_c <= 1'b0;
      sub_b <= 1'b0;
    end else if (busy) begin
      acc   <= {r_bit, acc[ACC_W-1:1]};
      smp   <= {1'b0, smp[SAMPLE_BITS-1:1]};
      add_c <= add_c_next;
      sub_b <= sub_b_next;
      if (cnt < CNT_W'(LF_W)) begin
        last_filtered <= {f_bit, last_filtered[LF_W-1:1]};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(ACC_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- rtl/adcc_serial_div.sv -----
// ----------------------------------------------------------------------------
// adcc_serial_div: restoring unsigned divider
// One quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module adcc_serial_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);
  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;
  logic             fits;

  always_comb begin
    shifted = {rem[DEN_W-1:0], quotient[NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den};
    fits    = ~trial[DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial[DEN_W:0] : shifted;
      quotient <= {quotient[NUM_W-2:0], fits};
      cnt      <= cnt + 1'b1;
      if (cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- rtl/adc_channel_conditioner.sv -----
// ----------------------------------------------------------------------------
// adc_channel_conditioner: three-channel ADC scan conditioning
// Exponential average of the pot channel, calibrated temperature and supply.
// ----------------------------------------------------------------------------
// Flow: a sample is accepted in ST_IDLE, both dividers start in ST_LOAD, and
//   ST_RUN waits for the 24-bit bit-serial accumulator update (pot samples),
//   both dividers (21-step supply divider) and a free result register. The next
//   sample is taken once the result is registered, even while its beat is pending.
// Reset (rst, synchronous): calibration registers to defaults, scan count,
//   accumulator, filtered value and stored samples to zero, no result pending.
module adc_channel_conditioner #(
  parameter int FILTER_SHIFT = 12,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [adcc_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [adcc_pkg::CAL_BITS-1:0]     cfg_data,
  adcc_in_if.sink                           adc,
  adcc_out_if.source                        result
);
  localparam int CAL_W = adcc_pkg::CAL_BITS;
  // magnitude of (temp_sample - temp_cal_low)
  localparam int MAG_W  = (SAMPLE_BITS > CAL_W) ? SAMPLE_BITS : CAL_W;
  // magnitude of the scaled temperature numerator (x80 needs 7 more bits)
  localparam int TNUM_W = MAG_W + 7;
  localparam int TQ_W   = TNUM_W + 2;
  // 330 * vref_cal
  localparam int VNUM_W = CAL_W + adcc_pkg::SCALE_BITS;

  // calibration registers
  logic [CAL_W-1:0] temp_cal_low;
  logic [CAL_W-1:0] temp_cal_high;
  logic [CAL_W-1:0] vref_cal;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal_low  <= adcc_pkg::TEMP_CAL_LOW_RST;
      temp_cal_high <= adcc_pkg::TEMP_CAL_HIGH_RST;
      vref_cal      <= adcc_pkg::VREF_CAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        adcc_pkg::REG_TEMP_CAL_LOW:  temp_cal_low  <= cfg_data;
        adcc_pkg::REG_TEMP_CAL_HIGH: temp_cal_high <= cfg_data;
        adcc_pkg::REG_VREF_CAL:      vref_cal      <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // control
  adcc_pkg::ctrl_state_t state, state_next;

  logic accept;
  logic ema_busy, tdiv_busy, vdiv_busy;
  logic done_all, out_free, load_out, div_start;
  logic out_valid;

  assign adc.ready = (state == adcc_pkg::ST_IDLE);
  assign accept    = adc.valid && adc.ready;
  assign done_all  = !ema_busy && !tdiv_busy && !vdiv_busy;
  assign out_free  = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    div_start  = 1'b0;
    case (state)
      adcc_pkg::ST_IDLE: begin
        if (accept) state_next = adcc_pkg::ST_LOAD;
      end
      adcc_pkg::ST_LOAD: begin
        // stored samples are up to date here; kick off both dividers
        div_start  = 1'b1;
        state_next = adcc_pkg::ST_RUN;
      end
      adcc_pkg::ST_RUN: begin
        if (done_all && out_free) begin
          load_out   = 1'b1;
          state_next = adcc_pkg::ST_IDLE;
        end
      end
      default: state_next = adcc_pkg::ST_IDLE;
    endcase
  end

  // scan tracking and stored samples
  logic [adcc_pkg::CHAN_BITS-1:0] scan_index;
  logic [adcc_pkg::CHAN_BITS-1:0] chan;
  logic [SAMPLE_BITS-1:0]         temp_sample;
  logic [SAMPLE_BITS-1:0]         vref_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index  <= adcc_pkg::CH_POT;
      temp_sample <= '0;
      vref_sample <= '0;
    end else if (accept) begin
      chan <= scan_index;
      if (scan_index == adcc_pkg::CH_TEMP) temp_sample <= adc.sample;
      if (scan_index == adcc_pkg::CH_VREF) vref_sample <= adc.sample;
      // count wraps on end of scan, otherwise sticks at the ignored code
      if (adc.end_of_sequence) begin
        scan_index <= adcc_pkg::CH_POT;
      end else if (scan_index != adcc_pkg::CH_IGNORED) begin
        scan_index <= scan_index + 1'b1;
      end
    end
  end

  // pot average, bit serial; runs only for pot samples
  logic [adcc_pkg::LF_BITS-1:0] last_filtered;

  adcc_ema_serial #(
    .FILTER_SHIFT (FILTER_SHIFT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_ema (
    .clk           (clk),
    .rst           (rst),
    .start         (accept && (scan_index == adcc_pkg::CH_POT)),
    .sample        (adc.sample),
    .busy          (ema_busy),
    .last_filtered (last_filtered)
  );

  // divider operands, sign-magnitude so both units stay unsigned
  logic [MAG_W:0]    tdiff;
  logic              tnum_neg;
  logic [MAG_W-1:0]  tmag;
  logic [TNUM_W-1:0] tnum;
  logic [CAL_W:0]    tden;
  logic              tden_neg;
  logic [CAL_W-1:0]  tden_mag;
  logic [VNUM_W-1:0] vnum;

  always_comb begin
    tdiff    = {1'b0, MAG_W'(temp_sample)} - {1'b0, MAG_W'(temp_cal_low)};
    tnum_neg = tdiff[MAG_W];
    tmag     = tnum_neg ? MAG_W'(-tdiff) : tdiff[MAG_W-1:0];
    tnum     = TNUM_W'(tmag) * TNUM_W'(adcc_pkg::TEMP_SPAN);
    tden     = {1'b0, temp_cal_high} - {1'b0, temp_cal_low};
    tden_neg = tden[CAL_W];
    tden_mag = tden_neg ? CAL_W'(-tden) : tden[CAL_W-1:0];
    vnum     = VNUM_W'(vref_cal) * VNUM_W'(adcc_pkg::SUPPLY_SCALE);
  end

  // quotient sign and zero-divisor faults, latched with the divider start
  logic                            tq_neg;
  logic [adcc_pkg::FAULT_BITS-1:0] fault;

  always_ff @(posedge clk) begin
    if (div_start) begin
      tq_neg                     <= tnum_neg ^ tden_neg;
      fault[adcc_pkg::FAULT_TEMP] <= (tden == '0);
      fault[adcc_pkg::FAULT_VREF] <= (vref_sample == '0);
    end
  end

  logic [TNUM_W-1:0] tquo;
  logic [VNUM_W-1:0] vquo;

  adcc_serial_div #(
    .NUM_W (TNUM_W),
    .DEN_W (CAL_W)
  ) u_temp_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tnum),
    .divisor  (tden_mag),
    .busy     (tdiv_busy),
    .quotient (tquo)
  );

  adcc_serial_div #(
    .NUM_W (VNUM_W),
    .DEN_W (SAMPLE_BITS)
  ) u_vref_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (vnum),
    .divisor  (vref_sample),
    .busy     (vdiv_busy),
    .quotient (vquo)
  );

  // truncating signed quotient, then the 30 degree offset
  logic [TQ_W-1:0] tq_ext;
  logic [TQ_W-1:0] tq_signed;
  logic [TQ_W-1:0] temp_full;

  always_comb begin
    tq_ext    = {2'b00, tquo};
    tq_signed = tq_neg ? (~tq_ext + 1'b1) : tq_ext;
    temp_full = tq_signed + TQ_W'(adcc_pkg::TEMP_COLD);
  end

  // result register: holds a beat while the next sample is worked on
  logic [adcc_pkg::CHAN_BITS-1:0]  out_chan;
  logic [adcc_pkg::LF_BITS-1:0]    out_pot;
  logic [adcc_pkg::TEMP_BITS-1:0]  out_temp;
  logic [adcc_pkg::VOLT_BITS-1:0]  out_volt;
  logic [adcc_pkg::FAULT_BITS-1:0] out_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_chan  <= chan;
      out_pot   <= last_filtered;
      out_temp  <= fault[adcc_pkg::FAULT_TEMP] ? '0 : temp_full[adcc_pkg::TEMP_BITS-1:0];
      out_volt  <= fault[adcc_pkg::FAULT_VREF] ? '0 : adcc_pkg::VOLT_BITS'(vquo);
      out_fault <= fault;
    end
  end

  assign result.valid             = out_valid;
  assign result.handled_channel   = out_chan;
  assign result.filtered_pot      = out_pot;
  assign result.temperature_c     = out_temp;
  assign result.supply_centivolts = out_volt;
  assign result.divide_fault      = out_fault;
endmodule

// ----- dv/tb_adc_channel_conditioner.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_channel_conditioner: self-checking bench of the ADC channel conditioner
// Drives scan sequences of ADC samples through the valid/ready sample stream,
// predicts every result beat in a scoreboard (scan count, exponential average,
// calibrated temperature, supply voltage, divide faults) and checks each beat
// field by field. Runs directed corner cases, then random scans under several
// calibration settings and sender/receiver idle mixes.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [adcc_pkg::CHAN_BITS-1:0]  chan;
  logic [adcc_pkg::LF_BITS-1:0]    filt;
  logic [adcc_pkg::TEMP_BITS-1:0]  temp;
  logic [adcc_pkg::VOLT_BITS-1:0]  volt;
  logic [adcc_pkg::FAULT_BITS-1:0] fault;
} cond_result_t;

class adcc_scoreboard;
  logic [adcc_pkg::CAL_BITS-1:0]  cal_low;
  logic [adcc_pkg::CAL_BITS-1:0]  cal_high;
  logic [adcc_pkg::CAL_BITS-1:0]  vref_cal;
  logic [adcc_pkg::CHAN_BITS-1:0] scan;
  logic [adcc_pkg::ACC_BITS-1:0]  acc;
  logic [adcc_pkg::LF_BITS-1:0]   last_filt;
  logic [adcc_pkg::CAL_BITS-1:0]  temp_smp;
  logic [adcc_pkg::CAL_BITS-1:0]  vref_smp;
  cond_result_t                   result_q[$];
  int                             mismatches;

  function new();
    cal_low    = adcc_pkg::TEMP_CAL_LOW_RST;
    cal_high   = adcc_pkg::TEMP_CAL_HIGH_RST;
    vref_cal   = adcc_pkg::VREF_CAL_RST;
    scan       = adcc_pkg::CH_POT;
    acc        = '0;
    last_filt  = '0;
    temp_smp   = '0;
    vref_smp   = '0;
    mismatches = 0;
  endfunction

  function void write_cal(logic [adcc_pkg::CFG_IDX_BITS-1:0] idx,
                          logic [adcc_pkg::CAL_BITS-1:0] data);
    case (idx)
      adcc_pkg::REG_TEMP_CAL_LOW:  cal_low  = data;
      adcc_pkg::REG_TEMP_CAL_HIGH: cal_high = data;
      adcc_pkg::REG_VREF_CAL:      vref_cal = data;
      default: ;  // unused index, write dropped
    endcase
  endfunction

  // Accepted sample beat: update the channel state, queue the expected result.
  function void note_sample(logic [adcc_pkg::CAL_BITS-1:0] smp, logic eos);
    cond_result_t                   r;
    logic [adcc_pkg::CHAN_BITS-1:0] ch;
    logic [adcc_pkg::LF_BITS-1:0]   f;
    longint                         num;
    longint                         den;
    longint                         t;
    longint                         v;
    ch = scan;
    case (ch)
      adcc_pkg::CH_POT: begin
        f         = acc[adcc_pkg::ACC_BITS-1 -: adcc_pkg::LF_BITS];
        acc       = acc - adcc_pkg::ACC_BITS'(f) + adcc_pkg::ACC_BITS'(smp);
        last_filt = f;
      end
      adcc_pkg::CH_TEMP: temp_smp = smp;
      adcc_pkg::CH_VREF: vref_smp = smp;
      default: ;
    endcase
    if (eos) begin
      scan = adcc_pkg::CH_POT;
    end else if (ch != adcc_pkg::CH_IGNORED) begin
      scan = ch + 2'd1;
    end

    r.chan  = ch;
    r.filt  = last_filt;
    r.temp  = '0;
    r.volt  = '0;
    r.fault = '0;
    den = longint'(cal_high) - longint'(cal_low);
    if (den == 0) begin
      r.fault[adcc_pkg::FAULT_TEMP] = 1'b1;
    end else begin
      num    = (longint'(temp_smp) - longint'(cal_low)) * adcc_pkg::TEMP_SPAN;
      t      = num / den + adcc_pkg::TEMP_COLD;  // truncates toward zero
      r.temp = t[adcc_pkg::TEMP_BITS-1:0];
    end
    if (vref_smp == 0) begin
      r.fault[adcc_pkg::FAULT_VREF] = 1'b1;
    end else begin
      v      = (longint'(adcc_pkg::SUPPLY_SCALE) * longint'(vref_cal)) / longint'(vref_smp);
      r.volt = v[adcc_pkg::VOLT_BITS-1:0];
    end
    result_q.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  function void check_result(cond_result_t got);
    cond_result_t exp_r;
    if (result_q.size() == 0) begin
      $error("result beat with no sample outstanding");
      mismatches++;
      return;
    end
    exp_r = result_q.pop_front();
    compare_field("handled_channel", 32'(exp_r.chan), 32'(got.chan));
    compare_field("filtered_pot", 32'(exp_r.filt), 32'(got.filt));
    compare_field("temperature_c", 32'(exp_r.temp), 32'(got.temp));
    compare_field("supply_centivolts", 32'(exp_r.volt), 32'(got.volt));
    compare_field("divide_fault", 32'(exp_r.fault), 32'(got.fault));
  endfunction

  function int pending();
    return result_q.size();
  endfunction
endclass

module tb_adc_channel_conditioner;

  localparam int CLK_HIGH       = 6;
  localparam int CLK_LOW        = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 40;
  localparam int QUIET_LIMIT    = 4000;  // cycles without any beat
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 128;   // non-ignored samples per phase
  localparam logic [adcc_pkg::CAL_BITS-1:0] SMP_MAX = '1;

  // index with no register behind it
  localparam logic [adcc_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              cfg_write = 1'b0;
  logic [adcc_pkg::CFG_IDX_BITS-1:0] cfg_index = adcc_pkg::REG_TEMP_CAL_LOW;
  logic [adcc_pkg::CAL_BITS-1:0]     cfg_data  = '0;

  adcc_in_if #(.SAMPLE_BITS(12)) adc_bus ();
  adcc_out_if                    result_bus ();

  adcc_scoreboard sb;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  useful_items = 0;   // accepted samples not on the ignored channel
  int  quiet_cycles = 0;
  logic in_beat;
  logic out_beat;

  adc_channel_conditioner #(
    .FILTER_SHIFT(12),
    .SAMPLE_BITS (12)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .adc      (adc_bus.sink),
    .result   (result_bus.source)
  );

  always begin
    #CLK_HIGH clk = 1'b1;
    #CLK_LOW  clk = 1'b0;
  end

  // Receiver: ready is redrawn every cycle; stall_pct of zero means always ready.
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: both streams are sampled at the edge, before this edge's updates.
  // Sample beats feed the predictor, result beats are checked in order.
  always @(posedge clk) begin
    in_beat  = !rst && adc_bus.valid && adc_bus.ready;
    out_beat = !rst && result_bus.valid && result_bus.ready;
    if (in_beat) begin
      if (sb.scan != adcc_pkg::CH_IGNORED) useful_items++;
      sb.note_sample(adc_bus.sample, adc_bus.end_of_sequence);
    end
    if (out_beat) begin
      sb.check_result('{chan:  result_bus.handled_channel,
                        filt:  result_bus.filtered_pot,
                        temp:  result_bus.temperature_c,
                        volt:  result_bus.supply_centivolts,
                        fault: result_bus.divide_fault});
    end
    quiet_cycles = (in_beat || out_beat) ? 0 : quiet_cycles + 1;
  end

  // Watchdog: a hung handshake ends the run.
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // One sample beat. Random gaps first (valid low), then hold valid until taken.
  // valid stays high on return so back-to-back beats need no extra edge.
  task automatic send_beat(input logic [adcc_pkg::CAL_BITS-1:0] smp, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      adc_bus.valid <= 1'b0;
      @(posedge clk);
    end
    adc_bus.valid           <= 1'b1;
    adc_bus.sample          <= smp;
    adc_bus.end_of_sequence <= eos;
    @(posedge clk);
    while (!adc_bus.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result beat has come back.
  task automatic drain(input int extra);
    adc_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write all three calibration registers plus a dummy write to the spare index.
  // Only called with the block idle.
  task automatic program_cal(input logic [adcc_pkg::CAL_BITS-1:0] lo,
                             input logic [adcc_pkg::CAL_BITS-1:0] hi,
                             input logic [adcc_pkg::CAL_BITS-1:0] vr);
    logic [adcc_pkg::CAL_BITS-1:0] junk;
    junk = adcc_pkg::CAL_BITS'($urandom());
    cfg_write <= 1'b1;
    cfg_index <= adcc_pkg::REG_TEMP_CAL_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    sb.write_cal(adcc_pkg::REG_TEMP_CAL_LOW, lo);
    cfg_index <= adcc_pkg::REG_TEMP_CAL_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    sb.write_cal(adcc_pkg::REG_TEMP_CAL_HIGH, hi);
    cfg_index <= adcc_pkg::REG_VREF_CAL;
    cfg_data  <= vr;
    @(posedge clk);
    sb.write_cal(adcc_pkg::REG_VREF_CAL, vr);
    cfg_index <= REG_SPARE;
    cfg_data  <= junk;
    @(posedge clk);
    sb.write_cal(REG_SPARE, junk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [adcc_pkg::CAL_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return SMP_MAX;
      default: return adcc_pkg::CAL_BITS'($urandom());
    endcase
  endfunction

  // Mostly clean three-sample scans; the rest are early ends, overlong scans
  // (samples on the ignored channel) and lone samples with a random flag.
  task automatic run_scans(input int count);
    int goal;
    int len;
    int kind;
    goal = useful_items + count;
    while (useful_items < goal) begin
      kind = $urandom_range(99);
      if (kind < 75) len = 3;
      else if (kind < 85) len = $urandom_range(2, 1);
      else if (kind < 95) len = $urandom_range(6, 4);
      else len = 0;
      if (len == 0) begin
        send_beat(rand_sample(), 1'($urandom()));
      end else begin
        for (int k = 0; k < len; k++) send_beat(rand_sample(), k == len - 1);
      end
    end
  endtask

  function automatic void set_idle(idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 53; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 53; end
      IDLE_BOTH: begin send_idle_pct = 34; recv_stall_pct = 34; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  initial begin
    logic [adcc_pkg::CAL_BITS-1:0] lo;
    sb = new();
    adc_bus.valid           = 1'b0;
    adc_bus.sample          = '0;
    adc_bus.end_of_sequence = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset calibration. Reference sample starts at zero, so the
    // supply fault shows until a nonzero reference sample is taken.
    set_idle(IDLE_NONE);
    send_beat('0, 1'b0);                  // pot, minimum
    send_beat(SMP_MAX, 1'b0);             // temp, maximum
    send_beat('0, 1'b1);                  // zero reference, end of scan
    send_beat(SMP_MAX, 1'b0);             // pot, maximum
    send_beat('0, 1'b0);                  // temp, minimum
    send_beat(SMP_MAX, 1'b0);             // reference, maximum
    send_beat(12'd1234, 1'b0);            // ignored channel
    send_beat(SMP_MAX, 1'b0);             // count holds at ignored
    send_beat(12'd2048, 1'b1);            // end flag on ignored channel
    send_beat(12'd1, 1'b1);               // scan ended on the pot channel
    send_beat(adcc_pkg::TEMP_CAL_LOW_RST, 1'b0);
    send_beat(adcc_pkg::TEMP_CAL_LOW_RST, 1'b1);    // temp at the 30 C point, early end
    send_beat(adcc_pkg::TEMP_CAL_HIGH_RST, 1'b0);
    send_beat(adcc_pkg::TEMP_CAL_HIGH_RST, 1'b0);   // temp at the 110 C point
    send_beat(12'd1, 1'b1);               // smallest reference, large supply

    // Steepest temperature slope and largest supply reading.
    drain(SETTLE_CYCLES);
    program_cal('0, 12'd1, SMP_MAX);
    send_beat('0, 1'b0);
    send_beat(SMP_MAX, 1'b0);
    send_beat(12'd1, 1'b1);

    // Zero temperature divisor, zero reference calibration.
    drain(SETTLE_CYCLES);
    program_cal(12'd2000, 12'd2000, '0);
    send_beat(12'd7, 1'b0);
    send_beat(12'd2000, 1'b0);
    send_beat(SMP_MAX, 1'b1);

    // Random phases: each one gets its own calibration and idle mix, with a
    // full drain halfway through.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain(SETTLE_CYCLES);
      lo = adcc_pkg::CAL_BITS'($urandom());
      case (ph)
        0: program_cal(adcc_pkg::TEMP_CAL_LOW_RST, adcc_pkg::TEMP_CAL_HIGH_RST,
                       adcc_pkg::VREF_CAL_RST);
        1: program_cal(SMP_MAX, '0, SMP_MAX);
        3: program_cal('0, SMP_MAX, 12'd1);
        4: program_cal(lo, lo, adcc_pkg::CAL_BITS'($urandom()));
        5: program_cal('0, '0, '0);
        default: program_cal(lo, adcc_pkg::CAL_BITS'($urandom()),
                             adcc_pkg::CAL_BITS'($urandom()));
      endcase
      set_idle(idle_mode_t'(ph % 4));
      run_scans(PHASE_ITEMS / 2);
      drain(1);
      run_scans(PHASE_ITEMS / 2);
    end

    drain(SETTLE_CYCLES);
    if (sb.pending() != 0) begin
      $error("%0d result beats never arrived", sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/adcc_pkg.sv
rtl/adcc_in_if.sv
rtl/adcc_out_if.sv
rtl/adcc_ema_serial.sv
rtl/adcc_serial_div.sv
rtl/adc_channel_conditioner.sv
dv/tb_adc_channel_conditioner.sv
